FILE: design/rgba_ob_pkg.sv
// shared types and constants for the rgba over blend pipeline
package rgba_ob_pkg;

  localparam logic [7:0] CH_MAX = 8'd255;

  // channel positions inside a pixel
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;
  localparam int CH_A = 3;
  localparam int N_COLOR = 3;
  localparam int N_LANES = 4;

  // numerator <= 255^3, divisor <= 255*255, quotient <= 255
  localparam int NUM_W = 24;
  localparam int DEN_W = 16;
  localparam int QUO_W = 8;

  localparam int PREP_STAGES = 2;
  localparam int DIV_STAGES  = QUO_W;
  localparam int N_STAGES    = PREP_STAGES + DIV_STAGES + 1;

  typedef logic [N_LANES-1:0][7:0] pix_t;

  typedef enum logic [1:0] {
    MODE_DST   = 2'd0,
    MODE_SRC   = 2'd1,
    MODE_BLEND = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e mode;
    pix_t  pix;
  } side_t;

endpackage

FILE: design/rgba_ob_prep.sv
// two-stage product and divisor setup ahead of the divider lanes
module rgba_ob_prep import rgba_ob_pkg::*; (
  input  logic                        clk_i,
  input  logic [PREP_STAGES-1:0]      en_i,
  input  pix_t                        src_i,
  input  pix_t                        dst_i,
  input  logic                        vis_i,
  output logic [N_COLOR-1:0][NUM_W-1:0] num_o,
  output logic [DEN_W-1:0]            den_o,
  output side_t                       side_o
);

  logic [N_COLOR-1:0][15:0] ps_d, ps_q, pd_d, pd_q;
  logic [7:0]               inv_d, inv_q, sa_q;
  logic [15:0]              dai_d, dai_q;
  side_t                    side1_d, side1_q, side2_q;
  logic [N_COLOR-1:0][NUM_W-1:0] num_d, num_q;
  logic [N_COLOR-1:0][NUM_W-1:0] mul;
  logic [DEN_W-1:0]         den_d, den_q;

  // stage one: the first multiplications and the case decision
  always_comb begin
    inv_d = CH_MAX - src_i[CH_A];
    for (int k = 0; k < N_COLOR; k++) begin
      ps_d[k] = {8'd0, src_i[k]} * {8'd0, src_i[CH_A]};
      pd_d[k] = {8'd0, dst_i[k]} * {8'd0, dst_i[CH_A]};
    end
    dai_d = {8'd0, dst_i[CH_A]} * {8'd0, inv_d};
    if (!vis_i || src_i[CH_A] == 8'd0) begin
      side1_d.mode = MODE_DST;
      side1_d.pix  = dst_i;
    end else if (src_i[CH_A] == CH_MAX || dst_i[CH_A] == 8'd0) begin
      side1_d.mode = MODE_SRC;
      side1_d.pix  = src_i;
    end else begin
      side1_d.mode = MODE_BLEND;
      side1_d.pix  = src_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ps_q    <= ps_d;
      pd_q    <= pd_d;
      inv_q   <= inv_d;
      sa_q    <= src_i[CH_A];
      dai_q   <= dai_d;
      side1_q <= side1_d;
    end
  end

  // stage two: times 255 as shift and subtract, second product, sums
  always_comb begin
    for (int k = 0; k < N_COLOR; k++) begin
      mul[k]   = {8'd0, pd_q[k]} * {16'd0, inv_q};
      num_d[k] = {ps_q[k], 8'd0} - {8'd0, ps_q[k]} + mul[k];
    end
    den_d = {sa_q, 8'd0} - {8'd0, sa_q} + dai_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      num_q   <= num_d;
      den_q   <= den_d;
      side2_q <= side1_q;
    end
  end

  assign num_o  = num_q;
  assign den_o  = den_q;
  assign side_o = side2_q;

endmodule

FILE: design/rgba_ob_div_lane.sv
// pipelined restoring divider, one quotient bit per stage
module rgba_ob_div_lane import rgba_ob_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output logic [QUO_W-1:0]      quo_o
);

  logic [NUM_W-1:0] rem_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  logic [NUM_W-1:0] rem_in [DIV_STAGES];
  logic [DEN_W-1:0] den_in [DIV_STAGES];
  logic [QUO_W-1:0] quo_in [DIV_STAGES];
  logic [NUM_W-1:0] rem_d  [DIV_STAGES];
  logic [QUO_W-1:0] quo_d  [DIV_STAGES];
  logic [NUM_W-1:0] sub    [DIV_STAGES];
  logic [NUM_W:0]   trial  [DIV_STAGES];

  always_comb begin
    rem_in[0] = num_i;
    den_in[0] = den_i;
    quo_in[0] = '0;
    for (int i = 1; i < DIV_STAGES; i++) begin
      rem_in[i] = rem_q[i-1];
      den_in[i] = den_q[i-1];
      quo_in[i] = quo_q[i-1];
    end
    for (int i = 0; i < DIV_STAGES; i++) begin
      // msb first: stage i decides quotient bit QUO_W-1-i
      sub[i]   = {{(NUM_W-DEN_W){1'b0}}, den_in[i]} << (QUO_W - 1 - i);
      trial[i] = {1'b0, rem_in[i]} - {1'b0, sub[i]};
      if (!trial[i][NUM_W]) begin
        rem_d[i] = trial[i][NUM_W-1:0];
        quo_d[i] = quo_in[i] | (QUO_W'(1) << (QUO_W - 1 - i));
      end else begin
        rem_d[i] = rem_in[i];
        quo_d[i] = quo_in[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (en_i[i]) begin
        rem_q[i] <= rem_d[i];
        den_q[i] <= den_in[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

FILE: design/rgba_ob_merge.sv
// merges lane quotients with the bypass pixel into the output register
module rgba_ob_merge import rgba_ob_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  pix_t  quo_i,
  input  side_t side_i,
  output pix_t  pix_o
);

  pix_t pix_d, pix_q;

  always_comb begin
    case (side_i.mode)
      MODE_BLEND: pix_d = quo_i;
      MODE_DST,
      MODE_SRC:   pix_d = side_i.pix;
      default:    pix_d = side_i.pix;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

FILE: design/rgba_over_blend.sv
// top level: porter-duff over blend of straight-alpha rgba8 pixels
//
// usage
// - input channel: in_valid_i / in_ready_o carry one source pixel, one
//   destination pixel and the layer visible flag per transfer
// - output channel: out_valid_o / out_ready_i carry the blended pixel
// - one pixel per cycle sustained while out_ready_i is high; results come out in input order
// - eleven register stages: two product stages, eight divider stages (one
//   quotient bit each), one output stage
// - three divider lanes run side by side on red, green and blue and share
//   the blend divisor; alpha is that divisor over 255 by shift and add,
//   delayed alongside the lanes
// - each stage has its own valid bit and moves whenever the stage after it
//   is empty or moving, so bubbles are squeezed out during a stall
// - while the receiver stalls, the held result stays put and new pixels
//   keep entering until every stage is full; then in_ready_o drops
// - reset empties the pipeline; results in flight are dropped, none is made up
module rgba_over_blend import rgba_ob_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_blue_i,
  input  logic [7:0] src_alpha_i,
  input  logic [7:0] dst_red_i,
  input  logic [7:0] dst_green_i,
  input  logic [7:0] dst_blue_i,
  input  logic [7:0] dst_alpha_i,
  input  logic       src_visible_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);

  logic [N_STAGES-1:0] v_q;
  logic [N_STAGES-1:0] en;

  pix_t  src_pix, dst_pix;
  logic [N_COLOR-1:0][NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  side_t prep_side;
  side_t side_q [DIV_STAGES];
  logic [DEN_W-1:0] alpha_sum;
  logic [7:0]       alpha_q [DIV_STAGES];
  pix_t  quo;
  pix_t  out_pix;

  // stage enables: a stage loads when it is empty or its item moves on
  always_comb begin
    en[N_STAGES-1] = !v_q[N_STAGES-1] || out_ready_i;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[N_STAGES-1];

  // pack the input pixels in channel order
  always_comb begin
    src_pix[CH_R] = src_red_i;
    src_pix[CH_G] = src_green_i;
    src_pix[CH_B] = src_blue_i;
    src_pix[CH_A] = src_alpha_i;
    dst_pix[CH_R] = dst_red_i;
    dst_pix[CH_G] = dst_green_i;
    dst_pix[CH_B] = dst_blue_i;
    dst_pix[CH_A] = dst_alpha_i;
  end

  rgba_ob_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (en[PREP_STAGES-1:0]),
    .src_i  (src_pix),
    .dst_i  (dst_pix),
    .vis_i  (src_visible_i),
    .num_o  (num),
    .den_o  (den),
    .side_o (prep_side)
  );

  // colour lanes: blended numerator over the shared divisor
  for (genvar g = 0; g < N_COLOR; g++) begin : g_color
    rgba_ob_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en[PREP_STAGES +: DIV_STAGES]),
      .num_i (num[g]),
      .den_i (den),
      .quo_o (quo[g])
    );
  end

  // alpha: floor(den / 255) as (den + (den >> 8) + 1) >> 8, exact up to 255*255
  assign alpha_sum = den + {8'd0, den[DEN_W-1:8]} + DEN_W'(1);

  // case decision, bypass pixel and alpha ride alongside the divider stages
  always_ff @(posedge clk_i) begin
    if (en[PREP_STAGES]) begin
      side_q[0]  <= prep_side;
      alpha_q[0] <= alpha_sum[DEN_W-1:8];
    end
    for (int i = 1; i < DIV_STAGES; i++) begin
      if (en[PREP_STAGES+i]) begin
        side_q[i]  <= side_q[i-1];
        alpha_q[i] <= alpha_q[i-1];
      end
    end
  end

  assign quo[CH_A] = alpha_q[DIV_STAGES-1];

  rgba_ob_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en[N_STAGES-1]),
    .quo_i  (quo),
    .side_i (side_q[DIV_STAGES-1]),
    .pix_o  (out_pix)
  );

  assign out_red_o   = out_pix[CH_R];
  assign out_green_o = out_pix[CH_G];
  assign out_blue_o  = out_pix[CH_B];
  assign out_alpha_o = out_pix[CH_A];

  // an empty output stage means the whole chain can move
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  // only a completely full, stalled pipeline refuses input
  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o == 1'b0) |-> (&v_q && !out_ready_i))
    else $error("input refused while a stage was free");

  // a stalled result is kept until its transfer
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_pix)))
    else $error("stalled result changed or dropped");

endmodule
